// ===== rtl/core/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the stroke splat spacing core.
// ----------------------------------------------------------------------------
package sss_pkg;

   // event kinds carried in req_tuser
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_POINT  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // register indexes of the csr port
   localparam logic [1:0] CSR_BRUSH_RADIUS = 2'd0;
   localparam logic [1:0] CSR_BRUSH_FLOW   = 2'd1;
   localparam logic [1:0] CSR_SPACING_RATE = 2'd2;

   // bit steps per serial operation
   localparam logic [4:0] MUL_STEPS      = 5'd25;
   localparam logic [4:0] THR_DIV_STEPS  = 5'd20;
   localparam logic [4:0] FRAC_DIV_STEPS = 5'd24;
   localparam logic [4:0] SQRT_STEPS     = 5'd21;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   // a: multiplicand / dividend bits / radicand, b: multiplier / initial remainder,
   // c: divisor
   typedef struct packed {
      logic       start;
      alu_op_type op;
      logic [4:0] steps;
      logic [41:0] a;
      logic [24:0] b;
      logic [23:0] c;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [48:0] result;
   } alu_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_DX2,
      S_DY2,
      S_SQRT,
      S_THA,
      S_THB,
      S_SETUP,
      S_THR,
      S_SLACK,
      S_CMP,
      S_DIV,
      S_EX,
      S_EY,
      S_ER,
      S_STORE,
      S_END,
      S_READ,
      S_LOAD
   } state_type;

endpackage

// ===== rtl/core/sss_serial_unit.sv =====
// ----------------------------------------------------------------------------
// sss_serial_unit
// Shared bit-serial multiplier, divider and square root, one bit per cycle.
// ----------------------------------------------------------------------------
module sss_serial_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  sss_pkg::alu_req_type req,
   output sss_pkg::alu_rsp_type rsp
);

   logic                busy_ff;
   logic                done_ff;
   logic [4:0]          cnt_ff;
   sss_pkg::alu_op_type op_ff;
   logic [48:0]         p_ff;
   logic [23:0]         a_ff;
   logic [24:0]         rem_ff;
   logic [23:0]         q_ff;
   logic [41:0]         rad_ff;
   logic [20:0]         root_ff;
   logic [23:0]         srem_ff;

   logic [24:0] mul_sum;
   logic [48:0] p_in;
   logic [24:0] rem_sh;
   logic [25:0] div_diff;
   logic [23:0] sq_r2;
   logic [23:0] sq_trial;
   logic [24:0] sq_diff;

   // shift-add multiply: multiplier in the low bits, consumed LSB first
   assign mul_sum = {1'b0, p_ff[48:25]} + {1'b0, a_ff};
   assign p_in    = p_ff[0] ? {mul_sum, p_ff[24:1]} : {1'b0, p_ff[48:1]};

   // restoring divide
   assign rem_sh   = {rem_ff[23:0], q_ff[23]};
   assign div_diff = {1'b0, rem_sh} - {2'b00, a_ff};

   // digit-by-digit square root, two radicand bits per step
   assign sq_r2    = {srem_ff[21:0], rad_ff[41:40]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_diff  = {1'b0, sq_r2} - {1'b0, sq_trial};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         op_ff   <= req.op;
         p_ff    <= {24'd0, req.b};
         a_ff    <= (req.op == sss_pkg::ALU_MUL) ? req.a[23:0] : req.c;
         rem_ff  <= req.b;
         q_ff    <= req.a[23:0];
         rad_ff  <= req.a;
         root_ff <= 21'd0;
         srem_ff <= 24'd0;
      end else if (busy_ff) begin
         unique case (op_ff)
            sss_pkg::ALU_MUL: begin
               p_ff <= p_in;
            end
            sss_pkg::ALU_DIV: begin
               if (!div_diff[25]) begin
                  rem_ff <= div_diff[24:0];
                  q_ff   <= {q_ff[22:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  q_ff   <= {q_ff[22:0], 1'b0};
               end
            end
            sss_pkg::ALU_SQRT: begin
               rad_ff <= {rad_ff[39:0], 2'b00};
               if (!sq_diff[24]) begin
                  srem_ff <= sq_diff[23:0];
                  root_ff <= {root_ff[19:0], 1'b1};
               end else begin
                  srem_ff <= sq_r2;
                  root_ff <= {root_ff[19:0], 1'b0};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp.done = done_ff;
      unique case (op_ff)
         sss_pkg::ALU_MUL:  rsp.result = p_ff;
         sss_pkg::ALU_DIV:  rsp.result = {25'd0, q_ff};
         sss_pkg::ALU_SQRT: rsp.result = {28'd0, root_ff};
         default:           rsp.result = 49'd0;
      endcase
   end

endmodule

// ===== rtl/core/stroke_splat_spacing_core.sv =====
// ----------------------------------------------------------------------------
// stroke_splat_spacing_core
// Turns pen events into evenly spaced brush splats along each stroke segment.
// ----------------------------------------------------------------------------
// One event is handled at a time. Start, and finish of an open stroke, give
// one splat each. A point walks the segment from the previous point: set-up
// (two squares, a square root, two threshold divides), then a walk step for
// every splat placed, dropped ones included, and a closing step for the
// segment. All arithmetic runs one bit per cycle in a single shared serial
// unit. Splats are collected in a MAX_SPLATS deep buffer and delivered
// after the walk, so that last and truncated are known before the first
// one leaves; each is read from the buffer before it is loaded into the
// output register. The next event is taken while the final splat still
// waits in the output register.
// ----------------------------------------------------------------------------
module stroke_splat_spacing_core #(
   parameter int MAX_SPLATS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pos_x[15:0], pos_y[31:16], pressure[39:32]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // splat_x[15:0], splat_y[31:16],
                                    // splat_radius[43:32], splat_strength[51:44]
   output logic        rsp_tlast,   // last
   output logic [0:0]  rsp_tuser,   // truncated
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [11:0] csr_wdata
);

   localparam int CW = $clog2(MAX_SPLATS + 1);
   localparam int AW = (MAX_SPLATS > 1) ? $clog2(MAX_SPLATS) : 1;

   // ---- registers ----
   logic [11:0] brush_radius_ff;
   logic [7:0]  brush_flow_ff;
   logic [7:0]  spacing_rate_ff;

   sss_pkg::state_type state_ff, state_in;
   logic        issued_ff;
   logic        active_ff;
   logic [23:0] travel_ff;
   logic [15:0] prev_x_ff, prev_y_ff;
   logic [11:0] prev_r_ff;

   logic [1:0]  cur_kind_ff;
   logic [15:0] cur_x_ff, cur_y_ff;
   logic [11:0] cur_r_ff;
   logic [33:0] sq_ff;        // dx^2 + dy^2
   logic [20:0] len_ff;       // segment length, Q17.4
   logic [19:0] ath_ff, bth_ff;
   logic [22:0] dsl_mag_ff;
   logic        dsl_neg_ff;
   logic [23:0] t_ff;         // position on segment, Q0.24
   logic [24:0] along_ff;     // travel since last splat
   logic [25:0] slack_ff;     // signed
   logic [15:0] ex_ff, ey_ff;
   logic [11:0] er_ff;
   logic [CW-1:0] cnt_ff;
   logic        drop_ff;
   logic [CW-1:0] rd_idx_ff;

   logic [43:0] mem [MAX_SPLATS];
   logic [43:0] rd_data_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_x_ff, rsp_y_ff;
   logic [11:0] rsp_r_ff;
   logic [7:0]  rsp_s_ff;
   logic        rsp_last_ff;
   logic        rsp_trunc_ff;

   // ---- combinational ----
   sss_pkg::alu_req_type alu_req;
   sss_pkg::alu_rsp_type alu_rsp;

   logic        accept;
   logic [19:0] rad_prod;
   logic [20:0] rad_rnd;
   logic [7:0]  rate_eff;
   logic        op_state;
   logic        mem_we;
   logic        out_free;
   logic        is_last;
   logic [21:0] la, lb;
   logic [22:0] diff, diff_mag;
   logic        lerp_neg;
   logic [48:0] lerp_sum;
   logic [25:0] lerp_val;
   logic [19:0] thr_clamped;
   logic [22:0] dsl;
   logic [24:0] one_minus_t;
   logic        cmp_hit;
   logic [25:0] end_sum;
   logic [23:0] travel_next;

   sss_serial_unit u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // ---- register file ----
   always_ff @(posedge clock) begin
      if (reset) begin
         brush_radius_ff <= 12'd160;
         brush_flow_ff   <= 8'd255;
         spacing_rate_ff <= 8'd80;
      end else if (csr_we) begin
         unique case (csr_addr)
            sss_pkg::CSR_BRUSH_RADIUS: brush_radius_ff <= csr_wdata;
            sss_pkg::CSR_BRUSH_FLOW:   brush_flow_ff   <= csr_wdata[7:0];
            sss_pkg::CSR_SPACING_RATE: spacing_rate_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign rate_eff = (spacing_rate_ff == 8'd0) ? 8'd1 : spacing_rate_ff;

   // ---- input side ----
   assign req_tready = (state_ff == sss_pkg::S_IDLE);
   assign accept     = req_tvalid & req_tready;

   // point radius, Q8.4, rounded
   assign rad_prod = {12'd0, req_tdata[39:32]} * {8'd0, brush_radius_ff};
   assign rad_rnd  = {1'b0, rad_prod} + 21'd128;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_last  = (rd_idx_ff == cnt_ff - CW'(1));

   // ---- interpolation operands: a + (b - a) * t ----
   always_comb begin
      la = 22'd0;
      lb = 22'd0;
      unique case (state_ff) inside
         sss_pkg::S_DX2, sss_pkg::S_EX: begin
            la = {{6{prev_x_ff[15]}}, prev_x_ff};
            lb = {{6{cur_x_ff[15]}}, cur_x_ff};
         end
         sss_pkg::S_DY2, sss_pkg::S_EY: begin
            la = {{6{prev_y_ff[15]}}, prev_y_ff};
            lb = {{6{cur_y_ff[15]}}, cur_y_ff};
         end
         sss_pkg::S_ER: begin
            la = {10'd0, prev_r_ff};
            lb = {10'd0, cur_r_ff};
         end
         sss_pkg::S_THR: begin
            la = {2'b00, ath_ff};
            lb = {2'b00, bth_ff};
         end
         default: begin
         end
      endcase
   end

   assign diff     = {lb[21], lb} - {la[21], la};
   assign lerp_neg = diff[22];
   assign diff_mag = lerp_neg ? (23'd0 - diff) : diff;
   // product rounded half away from zero
   assign lerp_sum = alu_rsp.result + 49'h800000;
   assign lerp_val = lerp_neg ? ({{4{la[21]}}, la} - {1'b0, lerp_sum[48:24]})
                              : ({{4{la[21]}}, la} + {1'b0, lerp_sum[48:24]});

   assign thr_clamped = (alu_rsp.result[19:0] < 20'd128) ? 20'd128 : alu_rsp.result[19:0];
   assign dsl         = {3'd0, bth_ff} - {3'd0, ath_ff} - {2'd0, len_ff};
   assign one_minus_t = 25'h1000000 - {1'b0, t_ff};
   // splat falls inside the segment when |dsl| * (1 - t) > slack
   assign cmp_hit     = alu_rsp.result > {4'd0, slack_ff[20:0], 24'd0};
   assign end_sum     = {1'b0, along_ff} + {1'b0, alu_rsp.result[48:24]};
   assign travel_next = (end_sum[25:24] != 2'b00) ? 24'hFFFFFF : end_sum[23:0];

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sss_pkg::S_IDLE: begin
            if (accept) state_in = sss_pkg::S_DISPATCH;
         end
         sss_pkg::S_DISPATCH: begin
            unique case (cur_kind_ff)
               sss_pkg::KIND_START:  state_in = sss_pkg::S_STORE;
               sss_pkg::KIND_POINT:  state_in = active_ff ? sss_pkg::S_DX2 : sss_pkg::S_IDLE;
               sss_pkg::KIND_FINISH: state_in = active_ff ? sss_pkg::S_STORE : sss_pkg::S_IDLE;
               default:              state_in = sss_pkg::S_IDLE;
            endcase
         end
         sss_pkg::S_DX2:  if (alu_rsp.done) state_in = sss_pkg::S_DY2;
         sss_pkg::S_DY2:  if (alu_rsp.done) state_in = sss_pkg::S_SQRT;
         sss_pkg::S_SQRT: if (alu_rsp.done) state_in = sss_pkg::S_THA;
         sss_pkg::S_THA:  if (alu_rsp.done) state_in = sss_pkg::S_THB;
         sss_pkg::S_THB:  if (alu_rsp.done) state_in = sss_pkg::S_SETUP;
         sss_pkg::S_SETUP: state_in = sss_pkg::S_THR;
         sss_pkg::S_THR:  if (alu_rsp.done) state_in = sss_pkg::S_SLACK;
         sss_pkg::S_SLACK: begin
            if (slack_ff[25])    state_in = sss_pkg::S_EX;
            else if (dsl_neg_ff) state_in = sss_pkg::S_CMP;
            else                 state_in = sss_pkg::S_END;
         end
         sss_pkg::S_CMP: begin
            if (alu_rsp.done) state_in = cmp_hit ? sss_pkg::S_DIV : sss_pkg::S_END;
         end
         sss_pkg::S_DIV: if (alu_rsp.done) state_in = sss_pkg::S_EX;
         sss_pkg::S_EX:  if (alu_rsp.done) state_in = sss_pkg::S_EY;
         sss_pkg::S_EY:  if (alu_rsp.done) state_in = sss_pkg::S_ER;
         sss_pkg::S_ER:  if (alu_rsp.done) state_in = sss_pkg::S_STORE;
         sss_pkg::S_STORE: begin
            state_in = (cur_kind_ff == sss_pkg::KIND_POINT) ? sss_pkg::S_THR : sss_pkg::S_READ;
         end
         sss_pkg::S_END: begin
            if (alu_rsp.done) begin
               state_in = (cnt_ff == CW'(0)) ? sss_pkg::S_IDLE : sss_pkg::S_READ;
            end
         end
         sss_pkg::S_READ: state_in = sss_pkg::S_LOAD;
         sss_pkg::S_LOAD: begin
            if (out_free) state_in = is_last ? sss_pkg::S_IDLE : sss_pkg::S_READ;
         end
         default: state_in = sss_pkg::S_IDLE;
      endcase
   end

   // ---- state outputs: serial unit commands, buffer write ----
   always_comb begin
      alu_req       = '0;
      alu_req.op    = sss_pkg::ALU_MUL;
      alu_req.steps = sss_pkg::MUL_STEPS;
      op_state      = 1'b0;
      unique case (state_ff) inside
         sss_pkg::S_DX2, sss_pkg::S_DY2: begin
            op_state  = 1'b1;
            alu_req.a = {19'd0, diff_mag};
            alu_req.b = {2'b00, diff_mag};
         end
         sss_pkg::S_SQRT: begin
            op_state      = 1'b1;
            alu_req.op    = sss_pkg::ALU_SQRT;
            alu_req.steps = sss_pkg::SQRT_STEPS;
            alu_req.a     = {sq_ff, 8'd0};
         end
         sss_pkg::S_THA, sss_pkg::S_THB: begin
            op_state      = 1'b1;
            alu_req.op    = sss_pkg::ALU_DIV;
            alu_req.steps = sss_pkg::THR_DIV_STEPS;
            alu_req.a     = (state_ff == sss_pkg::S_THA) ? {18'd0, prev_r_ff, 12'd0}
                                                         : {18'd0, cur_r_ff, 12'd0};
            alu_req.c     = {16'd0, rate_eff};
         end
         sss_pkg::S_THR, sss_pkg::S_EX, sss_pkg::S_EY, sss_pkg::S_ER: begin
            op_state  = 1'b1;
            alu_req.a = {19'd0, diff_mag};
            alu_req.b = {1'b0, t_ff};
         end
         sss_pkg::S_CMP: begin
            op_state  = 1'b1;
            alu_req.a = {19'd0, dsl_mag_ff};
            alu_req.b = one_minus_t;
         end
         sss_pkg::S_DIV: begin
            op_state      = 1'b1;
            alu_req.op    = sss_pkg::ALU_DIV;
            alu_req.steps = sss_pkg::FRAC_DIV_STEPS;
            alu_req.b     = {4'd0, slack_ff[20:0]};
            alu_req.c     = {1'b0, dsl_mag_ff};
         end
         sss_pkg::S_END: begin
            op_state  = 1'b1;
            alu_req.a = {21'd0, len_ff};
            alu_req.b = one_minus_t;
         end
         default: begin
         end
      endcase
      alu_req.start = op_state && !issued_ff;
      mem_we        = (state_ff == sss_pkg::S_STORE) && (cnt_ff < CW'(MAX_SPLATS));
   end

   // ---- control and stroke state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sss_pkg::S_IDLE;
         issued_ff    <= 1'b0;
         active_ff    <= 1'b0;
         travel_ff    <= 24'd0;
         prev_x_ff    <= 16'd0;
         prev_y_ff    <= 16'd0;
         prev_r_ff    <= 12'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (alu_req.start)     issued_ff <= 1'b1;
         else if (alu_rsp.done) issued_ff <= 1'b0;

         if (state_ff == sss_pkg::S_DISPATCH) begin
            if (cur_kind_ff == sss_pkg::KIND_START) begin
               // a stroke still open is simply abandoned
               prev_x_ff <= cur_x_ff;
               prev_y_ff <= cur_y_ff;
               prev_r_ff <= cur_r_ff;
               travel_ff <= 24'd0;
               active_ff <= 1'b1;
            end else if (cur_kind_ff == sss_pkg::KIND_FINISH && active_ff) begin
               travel_ff <= 24'd0;
               active_ff <= 1'b0;
            end
         end

         if (state_ff == sss_pkg::S_END && alu_rsp.done) begin
            travel_ff <= travel_next;
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
            prev_r_ff <= cur_r_ff;
         end

         if (state_ff == sss_pkg::S_LOAD && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                          rsp_valid_ff <= 1'b0;
      end
   end

   // ---- segment walk datapath ----
   always_ff @(posedge clock) begin
      unique case (state_ff)
         sss_pkg::S_IDLE: begin
            if (accept) begin
               cur_kind_ff <= req_tuser;
               cur_x_ff    <= req_tdata[15:0];
               cur_y_ff    <= req_tdata[31:16];
               cur_r_ff    <= rad_rnd[19:8];
            end
         end
         sss_pkg::S_DISPATCH: begin
            cnt_ff    <= CW'(0);
            drop_ff   <= 1'b0;
            rd_idx_ff <= CW'(0);
            if (cur_kind_ff == sss_pkg::KIND_START) begin
               ex_ff <= cur_x_ff;
               ey_ff <= cur_y_ff;
               er_ff <= cur_r_ff;
            end else begin
               // finish repeats the stored point
               ex_ff <= prev_x_ff;
               ey_ff <= prev_y_ff;
               er_ff <= prev_r_ff;
            end
         end
         sss_pkg::S_DX2:  if (alu_rsp.done) sq_ff <= alu_rsp.result[33:0];
         sss_pkg::S_DY2:  if (alu_rsp.done) sq_ff <= sq_ff + alu_rsp.result[33:0];
         sss_pkg::S_SQRT: if (alu_rsp.done) len_ff <= alu_rsp.result[20:0];
         sss_pkg::S_THA:  if (alu_rsp.done) ath_ff <= thr_clamped;
         sss_pkg::S_THB:  if (alu_rsp.done) bth_ff <= thr_clamped;
         sss_pkg::S_SETUP: begin
            dsl_neg_ff <= dsl[22];
            dsl_mag_ff <= dsl[22] ? (23'd0 - dsl) : dsl;
            t_ff       <= 24'd0;
            along_ff   <= {1'b0, travel_ff};
         end
         sss_pkg::S_THR: begin
            if (alu_rsp.done) slack_ff <= {6'd0, lerp_val[19:0]} - {1'b0, along_ff};
         end
         sss_pkg::S_SLACK: begin
            // already past the threshold: splat at the current position
            if (slack_ff[25]) along_ff <= 25'd0;
         end
         sss_pkg::S_DIV: begin
            if (alu_rsp.done) begin
               t_ff     <= t_ff + alu_rsp.result[23:0];
               along_ff <= 25'd0;
            end
         end
         sss_pkg::S_EX: if (alu_rsp.done) ex_ff <= lerp_val[15:0];
         sss_pkg::S_EY: if (alu_rsp.done) ey_ff <= lerp_val[15:0];
         sss_pkg::S_ER: if (alu_rsp.done) er_ff <= lerp_val[11:0];
         sss_pkg::S_STORE: begin
            // beyond the limit the walk goes on, the splat is dropped
            if (mem_we) cnt_ff  <= cnt_ff + CW'(1);
            else        drop_ff <= 1'b1;
         end
         sss_pkg::S_LOAD: begin
            if (out_free) begin
               rsp_x_ff     <= rd_data_ff[15:0];
               rsp_y_ff     <= rd_data_ff[31:16];
               rsp_r_ff     <= rd_data_ff[43:32];
               rsp_s_ff     <= brush_flow_ff;
               rsp_last_ff  <= is_last;
               rsp_trunc_ff <= drop_ff;
               rd_idx_ff    <= rd_idx_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // ---- splat buffer ----
   always_ff @(posedge clock) begin
      if (mem_we) mem[cnt_ff[AW-1:0]] <= {er_ff, ey_ff, ex_ff};
      rd_data_ff <= mem[rd_idx_ff[AW-1:0]];
   end

   // ---- response side ----
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_s_ff, rsp_r_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_trunc_ff;

endmodule
